// ===== src/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types, sizes and ring index helpers for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH       = 16;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int MODE_W      = 3;
  localparam int FILL_W      = 5;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_REAR  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_REAR   = 3'd3,
    MODE_PEEK_FRONT = 3'd4,
    MODE_PEEK_REAR  = 3'd5
  } mode_t;

  // Lowest member last: ok lands in bit 0 of the packed word.
  typedef struct packed {
    logic                     full;
    logic                     empty;
    logic [FILL_W-1:0]        fill;
    logic signed [DATA_W-1:0] data;
    logic                     ok;
  } result_t;

  typedef struct packed {
    logic                     en;
    logic                     we;
    idx_t                     addr;
    logic signed [DATA_W-1:0] wdata;
  } mem_req_t;

  function automatic idx_t ring_next(idx_t i);
    return (i == idx_t'(DEPTH - 1)) ? '0 : i + idx_t'(1);
  endfunction

  function automatic idx_t ring_prev(idx_t i);
    return (i == '0) ? idx_t'(DEPTH - 1) : i - idx_t'(1);
  endfunction

endpackage

// ===== src/deq_ram.sv =====
// ----------------------------------------------------------------------------
// deq_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== src/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// deq_ctrl
// Front/rear/count bookkeeping, RAM request sequencing and result register.
// ----------------------------------------------------------------------------
module deq_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [deq_pkg::MODE_W-1:0]       in_mode,
  input  logic signed [deq_pkg::DATA_W-1:0] in_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output deq_pkg::result_t                 res,
  output deq_pkg::mem_req_t                mem_req,
  input  logic signed [deq_pkg::DATA_W-1:0] rd_data
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t          state;
  deq_pkg::idx_t   front, front_next;
  deq_pkg::idx_t   rear, rear_next;
  deq_pkg::cnt_t   count, count_next;
  logic            accept;
  logic            is_full, is_empty;
  logic            ok_c, rd_c;
  logic            out_valid_next;

  assign is_full  = (count == deq_pkg::cnt_t'(deq_pkg::DEPTH));
  assign is_empty = (count == '0);
  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    front_next    = front;
    rear_next     = rear;
    count_next    = count;
    ok_c          = 1'b0;
    rd_c          = 1'b0;
    mem_req       = '0;
    mem_req.wdata = in_value;
    unique case (deq_pkg::mode_t'(in_mode))
      deq_pkg::MODE_PUSH_FRONT: begin
        if (!is_full) begin
          front_next   = deq_pkg::ring_prev(front);
          count_next   = count + deq_pkg::cnt_t'(1);
          ok_c         = 1'b1;
          mem_req.we   = 1'b1;
          mem_req.addr = deq_pkg::ring_prev(front);
        end
      end
      deq_pkg::MODE_PUSH_REAR: begin
        if (!is_full) begin
          rear_next    = deq_pkg::ring_next(rear);
          count_next   = count + deq_pkg::cnt_t'(1);
          ok_c         = 1'b1;
          mem_req.we   = 1'b1;
          mem_req.addr = rear;
        end
      end
      deq_pkg::MODE_POP_FRONT: begin
        if (!is_empty) begin
          front_next   = deq_pkg::ring_next(front);
          count_next   = count - deq_pkg::cnt_t'(1);
          ok_c         = 1'b1;
          rd_c         = 1'b1;
          mem_req.addr = front;
        end
      end
      deq_pkg::MODE_POP_REAR: begin
        if (!is_empty) begin
          rear_next    = deq_pkg::ring_prev(rear);
          count_next   = count - deq_pkg::cnt_t'(1);
          ok_c         = 1'b1;
          rd_c         = 1'b1;
          mem_req.addr = deq_pkg::ring_prev(rear);
        end
      end
      deq_pkg::MODE_PEEK_FRONT: begin
        if (!is_empty) begin
          ok_c         = 1'b1;
          rd_c         = 1'b1;
          mem_req.addr = front;
        end
      end
      deq_pkg::MODE_PEEK_REAR: begin
        if (!is_empty) begin
          ok_c         = 1'b1;
          rd_c         = 1'b1;
          mem_req.addr = deq_pkg::ring_prev(rear);
        end
      end
      default: begin
      end
    endcase
    // Only a beat that is actually taken touches the RAM.
    mem_req.en = accept && (mem_req.we || rd_c);
    mem_req.we = mem_req.we && accept;
  end

  always_comb begin
    out_valid_next = out_valid && !out_ready;
    if (accept) begin
      out_valid_next = !rd_c;
    end else if (state == ST_READ) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      front     <= '0;
      rear      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      if (accept) begin
        front <= front_next;
        rear  <= rear_next;
        count <= count_next;
        if (rd_c) begin
          state <= ST_READ;
        end
      end else if (state == ST_READ) begin
        state <= ST_IDLE;
      end
    end
  end

  // Result payload: flags at accept, read data while in ST_READ.
  always_ff @(posedge clk) begin
    if (accept) begin
      res.ok    <= ok_c;
      res.data  <= '0;
      res.fill  <= deq_pkg::FILL_W'(count_next);
      res.empty <= (count_next == '0);
      res.full  <= (count_next == deq_pkg::cnt_t'(deq_pkg::DEPTH));
    end else if (state == ST_READ) begin
      res.data <= rd_data;
    end
  end

endmodule

// ===== src/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue
// Fixed-depth deque of signed 32-bit values held in a ring buffer RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ channel, one beat per request; every request
//   returns exactly one result beat on the m_ channel, in request order.
//   s_tdata: mode (push/pop/peek at front or rear) and the value to push.
//   m_tdata: ok flag, popped or peeked value (zero otherwise), fill count
//   after the request, and empty/full flags.
// Results:
//   Pushes, rejected requests and unused modes show their result in the cycle
//   after acceptance and the next request may enter in that same cycle.
//   Pops and peeks wait on the registered RAM read port: the read data is
//   captured in ST_READ, and no new request enters until the result shows.
// Reset:
//   rst clears the indices and the count; the queue is empty afterwards and
//   the RAM contents are only read once written.
// Stall:
//   A result held on m_ while m_tready is low blocks new requests; a pending
//   result that is taken frees the slot for a request in the same cycle.
// ----------------------------------------------------------------------------
module double_ended_queue (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [2:0] mode, [34:3] value, [39:35] zero
  input  logic [deq_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [0] ok, [32:1] data_out, [37:33] fill_count, [38] is_empty, [39] is_full
  output logic [deq_pkg::OUT_TDATA_W-1:0]    m_tdata
);

  deq_pkg::mem_req_t                  mem_req;
  deq_pkg::result_t                   res;
  logic signed [deq_pkg::DATA_W-1:0]  rd_data;
  logic [deq_pkg::DATA_W-1:0]         rd_raw;

  assign rd_data = signed'(rd_raw);
  assign m_tdata = res;

  deq_ram #(
    .Width (deq_pkg::DATA_W),
    .Depth (deq_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (mem_req.en),
    .we    (mem_req.we),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (rd_raw)
  );

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_mode   (s_tdata[deq_pkg::MODE_W-1:0]),
    .in_value  (s_tdata[deq_pkg::MODE_W +: deq_pkg::DATA_W]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .res       (res),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

`ifndef SYNTHESIS
  a_no_take_while_stalled: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("request taken while result is stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res.empty == (res.fill == '0)))
    else $error("empty flag disagrees with fill count");

  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res.full == (res.fill == deq_pkg::FILL_W'(deq_pkg::DEPTH))))
    else $error("full flag disagrees with fill count");

  a_failed_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !res.ok) |-> (res.data == '0))
    else $error("rejected request returned nonzero data");
`endif

endmodule
